// ===== src/tcur_pkg.sv =====
// Shared types and constants of the text terminal cursor engine.
// Used by the channel interfaces and by every module of the block; depends on nothing.
package tcur_pkg;

   // Screen limits and tab spacing.
   localparam int MAX_COLUMNS = 80;
   localparam int MAX_ROWS    = 40;
   localparam int TAB_STOP    = 4;

   // Field widths.
   localparam int CHAR_W  = 8;
   localparam int COL_W   = 7;
   localparam int ROW_W   = 6;
   localparam int INDEX_W = 2;
   localparam int DATA_W  = 7;

   // Depth of the queue between the classifier and the executor.
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Character codes with a meaning of their own.
   localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
   localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
   localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
   localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
   localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
   localparam logic [CHAR_W-1:0] CH_DEL   = 8'h7F;

   // Configuration register indexes.
   typedef enum logic [INDEX_W-1:0] {
      CSR_COLUMNS = 2'd0,
      CSR_ROWS    = 2'd1
   } csr_index_type;

   // Kinds of operation the classifier hands to the executor.
   typedef enum logic [2:0] {
      OP_CR,
      OP_LF,
      OP_ERASE,
      OP_TAB,
      OP_PUT
   } op_type;

   typedef enum logic {
      EV_CELL   = 1'b0,
      EV_SCROLL = 1'b1
   } event_kind_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_RUN,
      BK_SCROLL
   } back_state_type;

   typedef struct packed {
      op_type              op;
      logic [CHAR_W-1:0]   char_code;
   } queue_entry_type;

   typedef struct packed {
      event_kind_type      event_kind;
      logic [COL_W-1:0]    cell_column;
      logic [ROW_W-1:0]    cell_row;
      logic [CHAR_W-1:0]   cell_char;
      logic [ROW_W-1:0]    top_row;
      logic                last;
   } rsp_type;

endpackage

// ===== src/tcur_ifs.sv =====
// Channel interfaces of the text terminal cursor engine: input, result and configuration.
// Depends on tcur_pkg for the field widths.
interface tcur_req_if;
   logic                          valid;
   logic                          ready;
   logic [tcur_pkg::CHAR_W-1:0]   char_code;

   modport source (output valid, output char_code, input ready);
   modport sink   (input valid, input char_code, output ready);
endinterface

interface tcur_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          event_kind;
   logic [tcur_pkg::COL_W-1:0]    cell_column;
   logic [tcur_pkg::ROW_W-1:0]    cell_row;
   logic [tcur_pkg::CHAR_W-1:0]   cell_char;
   logic [tcur_pkg::ROW_W-1:0]    top_row;
   logic                          last;

   modport source (output valid, output event_kind, output cell_column, output cell_row,
                   output cell_char, output top_row, output last, input ready);
   modport sink   (input valid, input event_kind, input cell_column, input cell_row,
                   input cell_char, input top_row, input last, output ready);
endinterface

interface tcur_csr_if;
   logic                          valid;
   logic                          ready;
   logic [tcur_pkg::INDEX_W-1:0]  index;
   logic [tcur_pkg::DATA_W-1:0]   data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== src/tcur_front.sv =====
// Front end: accepts character items and classifies them into executor operations.
// Depends on tcur_pkg and tcur_req_if.
module tcur_front (
   input  logic                      clock,
   input  logic                      reset,
   tcur_req_if.sink                  req_if,
   output logic                      push,
   output tcur_pkg::queue_entry_type push_entry,
   input  logic                      queue_full
);

   logic                      hold_valid_ff, hold_valid_in;
   tcur_pkg::queue_entry_type entry_ff, entry_in;
   logic                      accept;
   tcur_pkg::op_type          op_class;

   always_comb begin
      case (req_if.char_code)
         tcur_pkg::CH_CR:  op_class = tcur_pkg::OP_CR;
         tcur_pkg::CH_LF:  op_class = tcur_pkg::OP_LF;
         tcur_pkg::CH_BS:  op_class = tcur_pkg::OP_ERASE;
         tcur_pkg::CH_DEL: op_class = tcur_pkg::OP_ERASE;
         tcur_pkg::CH_TAB: op_class = tcur_pkg::OP_TAB;
         default:          op_class = tcur_pkg::OP_PUT;
      endcase
   end

   assign push         = hold_valid_ff && !queue_full;
   assign req_if.ready = !hold_valid_ff || push;
   assign accept       = req_if.valid && req_if.ready;
   assign push_entry   = entry_ff;

   always_comb begin
      hold_valid_in = hold_valid_ff;
      entry_in      = entry_ff;
      if (accept) begin
         hold_valid_in      = 1'b1;
         entry_in.op        = op_class;
         entry_in.char_code = req_if.char_code;
      end else if (push) begin
         hold_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

// ===== src/tcur_queue.sv =====
// Short first-in first-out queue of classified operations between front and back ends.
// Depends on tcur_pkg.
module tcur_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  tcur_pkg::queue_entry_type push_entry,
   output logic                      full,
   input  logic                      pop,
   output tcur_pkg::queue_entry_type head,
   output logic                      empty
);

   localparam logic [tcur_pkg::QPTR_W-1:0] LAST_PTR = tcur_pkg::QPTR_W'(tcur_pkg::QUEUE_DEPTH - 1);
   localparam logic [tcur_pkg::QCNT_W-1:0] FULL_CNT = tcur_pkg::QCNT_W'(tcur_pkg::QUEUE_DEPTH);

   tcur_pkg::queue_entry_type         slot_ff [tcur_pkg::QUEUE_DEPTH];
   logic [tcur_pkg::QPTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [tcur_pkg::QPTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [tcur_pkg::QCNT_W-1:0]       count_ff, count_in;
   logic                              do_push, do_pop;

   assign full    = (count_ff == FULL_CNT);
   assign empty   = (count_ff == '0);
   assign head    = slot_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ===== src/tcur_back.sv =====
// Back end: executes classified operations on the cursor and top-row state and
// produces result items, one per cycle within an operation while the result channel is ready, and
// also owns the configuration registers. Depends on tcur_pkg, tcur_rsp_if and tcur_csr_if.
module tcur_back (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      queue_empty,
   input  tcur_pkg::queue_entry_type queue_head,
   output logic                      pop,
   tcur_csr_if.sink                  csr_if,
   tcur_rsp_if.source                rsp_if
);

   localparam logic [tcur_pkg::COL_W-1:0] COL_MAX = tcur_pkg::COL_W'(tcur_pkg::MAX_COLUMNS);
   localparam logic [tcur_pkg::ROW_W-1:0] ROW_MAX = tcur_pkg::ROW_W'(tcur_pkg::MAX_ROWS);
   localparam logic [tcur_pkg::COL_W-1:0] COL_TAB = tcur_pkg::COL_W'(tcur_pkg::TAB_STOP);

   tcur_pkg::back_state_type       state_ff, state_in;
   tcur_pkg::op_type               op_ff, op_in;
   logic [tcur_pkg::CHAR_W-1:0]    char_ff, char_in;
   logic [tcur_pkg::COL_W-1:0]     col_ff, col_in;
   logic [tcur_pkg::ROW_W-1:0]     row_ff, row_in;
   logic [tcur_pkg::ROW_W-1:0]     top_ff, top_in;
   logic [tcur_pkg::COL_W-1:0]     ncols_ff, ncols_in;
   logic [tcur_pkg::ROW_W-1:0]     nrows_ff, nrows_in;
   logic                           out_valid_ff, out_valid_in;
   tcur_pkg::rsp_type              out_ff, out_in;

   logic                           slot_free;
   logic                           emit;
   logic                           csr_write;
   logic [tcur_pkg::COL_W-1:0]     col_next;
   logic                           wrap;
   logic                           last_row;
   logic                           tab_done;
   logic                           put_done;
   logic [tcur_pkg::ROW_W-1:0]     top_next;
   logic [tcur_pkg::COL_W-1:0]     cfg_cols;
   logic [tcur_pkg::ROW_W-1:0]     cfg_rows;

   assign slot_free     = !out_valid_ff || rsp_if.ready;
   assign csr_if.ready  = 1'b1;
   assign csr_write     = csr_if.valid;
   assign pop           = (state_ff == tcur_pkg::BK_IDLE) && !queue_empty;

   assign col_next = col_ff + 1'b1;
   assign wrap     = (col_next >= ncols_ff);
   assign last_row = ((row_ff + 1'b1) >= nrows_ff);
   assign tab_done = ((col_next % COL_TAB) == '0);
   assign put_done = (op_ff == tcur_pkg::OP_PUT) || wrap || tab_done;
   assign top_next = ((top_ff + 1'b1) >= nrows_ff) ? '0 : top_ff + 1'b1;

   // Out-of-range register values act as the nearest limit; rows use the low six bits.
   always_comb begin
      cfg_cols = csr_if.data[tcur_pkg::COL_W-1:0];
      if (cfg_cols == '0) begin
         cfg_cols = tcur_pkg::COL_W'(1);
      end else if (cfg_cols > COL_MAX) begin
         cfg_cols = COL_MAX;
      end
      cfg_rows = csr_if.data[tcur_pkg::ROW_W-1:0];
      if (cfg_rows == '0) begin
         cfg_rows = tcur_pkg::ROW_W'(1);
      end else if (cfg_rows > ROW_MAX) begin
         cfg_rows = ROW_MAX;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tcur_pkg::BK_IDLE: begin
            if (!queue_empty) begin
               state_in = tcur_pkg::BK_RUN;
            end
         end
         tcur_pkg::BK_RUN: begin
            case (op_ff)
               tcur_pkg::OP_CR: state_in = tcur_pkg::BK_IDLE;
               tcur_pkg::OP_LF: begin
                  state_in = last_row ? tcur_pkg::BK_SCROLL : tcur_pkg::BK_IDLE;
               end
               tcur_pkg::OP_ERASE: begin
                  if (col_ff == '0 || slot_free) begin
                     state_in = tcur_pkg::BK_IDLE;
                  end
               end
               default: begin
                  if (slot_free) begin
                     if (wrap && last_row) begin
                        state_in = tcur_pkg::BK_SCROLL;
                     end else if (put_done) begin
                        state_in = tcur_pkg::BK_IDLE;
                     end
                  end
               end
            endcase
         end
         tcur_pkg::BK_SCROLL: begin
            if (slot_free) begin
               state_in = tcur_pkg::BK_IDLE;
            end
         end
         default: state_in = tcur_pkg::BK_IDLE;
      endcase
   end

   // Datapath and result generation.
   always_comb begin
      op_in    = op_ff;
      char_in  = char_ff;
      col_in   = col_ff;
      row_in   = row_ff;
      top_in   = top_ff;
      ncols_in = ncols_ff;
      nrows_in = nrows_ff;
      emit     = 1'b0;
      out_in   = out_ff;

      case (state_ff)
         tcur_pkg::BK_IDLE: begin
            if (!queue_empty) begin
               op_in   = queue_head.op;
               char_in = queue_head.char_code;
               if (col_ff >= ncols_ff) begin
                  col_in = ncols_ff - 1'b1;
               end
               if (row_ff >= nrows_ff) begin
                  row_in = nrows_ff - 1'b1;
               end
               if (top_ff >= nrows_ff) begin
                  top_in = '0;
               end
            end
         end
         tcur_pkg::BK_RUN: begin
            case (op_ff)
               tcur_pkg::OP_CR: col_in = '0;
               tcur_pkg::OP_LF: begin
                  col_in = '0;
                  if (!last_row) begin
                     row_in = row_ff + 1'b1;
                  end
               end
               tcur_pkg::OP_ERASE: begin
                  if (col_ff != '0 && slot_free) begin
                     emit               = 1'b1;
                     col_in             = col_ff - 1'b1;
                     out_in.event_kind  = tcur_pkg::EV_CELL;
                     out_in.cell_column = col_ff - 1'b1;
                     out_in.cell_row    = row_ff;
                     out_in.cell_char   = tcur_pkg::CH_SPACE;
                     out_in.top_row     = top_ff;
                     out_in.last        = 1'b1;
                  end
               end
               default: begin
                  if (slot_free) begin
                     emit               = 1'b1;
                     out_in.event_kind  = tcur_pkg::EV_CELL;
                     out_in.cell_column = col_ff;
                     out_in.cell_row    = row_ff;
                     out_in.cell_char   = (op_ff == tcur_pkg::OP_TAB) ? tcur_pkg::CH_SPACE
                                                                       : char_ff;
                     out_in.top_row     = top_ff;
                     out_in.last        = put_done && !(wrap && last_row);
                     if (wrap) begin
                        col_in = '0;
                        if (!last_row) begin
                           row_in = row_ff + 1'b1;
                        end
                     end else begin
                        col_in = col_next;
                     end
                  end
               end
            endcase
         end
         tcur_pkg::BK_SCROLL: begin
            if (slot_free) begin
               emit               = 1'b1;
               top_in             = top_next;
               row_in             = nrows_ff - 1'b1;
               out_in.event_kind  = tcur_pkg::EV_SCROLL;
               out_in.cell_column = '0;
               out_in.cell_row    = '0;
               out_in.cell_char   = tcur_pkg::CH_SPACE;
               out_in.top_row     = top_next;
               out_in.last        = 1'b1;
            end
         end
         default: begin
         end
      endcase

      // Column or row writes home the cursor; the user writes only while idle, not enforced.
      if (csr_write) begin
         case (csr_if.index)
            tcur_pkg::CSR_COLUMNS: begin
               ncols_in = cfg_cols;
               col_in   = '0;
               row_in   = '0;
               top_in   = '0;
            end
            tcur_pkg::CSR_ROWS: begin
               nrows_in = cfg_rows;
               col_in   = '0;
               row_in   = '0;
               top_in   = '0;
            end
            default: begin
            end
         endcase
      end

      if (emit) begin
         out_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tcur_pkg::BK_IDLE;
         col_ff       <= '0;
         row_ff       <= '0;
         top_ff       <= '0;
         ncols_ff     <= COL_MAX;
         nrows_ff     <= ROW_MAX;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         top_ff       <= top_in;
         ncols_ff     <= ncols_in;
         nrows_ff     <= nrows_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff   <= op_in;
      char_ff <= char_in;
      out_ff  <= out_in;
   end

   assign rsp_if.valid       = out_valid_ff;
   assign rsp_if.event_kind  = out_ff.event_kind;
   assign rsp_if.cell_column = out_ff.cell_column;
   assign rsp_if.cell_row    = out_ff.cell_row;
   assign rsp_if.cell_char   = out_ff.cell_char;
   assign rsp_if.top_row     = out_ff.top_row;
   assign rsp_if.last        = out_ff.last;

endmodule

// ===== src/text_terminal_cursor_engine.sv =====
// Top level of the text terminal cursor engine: front end, operation queue and back end.
// Depends on tcur_pkg, the channel interfaces, tcur_front, tcur_queue and tcur_back.
//
//   channel   role     carries
//   req_if    sink     char_code, one character or control byte per item
//   rsp_if    source   event_kind, cell_column, cell_row, cell_char, top_row, last
//   csr_if    sink     index (0 columns, 1 rows) and data; always ready
//
// The back end first fetches an operation from the queue and then gives one result
// item per cycle while the result channel is ready: an erase gives one item (none at
// the left edge), a printable byte one, or two when it wraps off the bottom row and
// scrolls, a carriage return none, a line feed none or a scroll, a tab up to five.
// The front end classifies the next byte while the back end works, and the output
// register takes a new result in the same cycle as the previous one is taken, so results
// of one operation leave back to back while the result channel is ready.
// A stalled result channel holds the back end; the front end then fills the queue and
// stops accepting. Reset is synchronous and leaves 80 columns, 40 rows, the cursor at
// the top left and the top row at 0.
//
// The character cells themselves are held by whatever consumes the result stream: every
// change to a cell and every scroll (whose new bottom row is all spaces) is reported as
// an item, and nothing here ever reads a cell back.
module text_terminal_cursor_engine (
   input  logic         clock,
   input  logic         reset,
   tcur_req_if.sink     req_if,
   tcur_rsp_if.source   rsp_if,
   tcur_csr_if.sink     csr_if
);

   logic                      push;
   tcur_pkg::queue_entry_type push_entry;
   logic                      queue_full;
   logic                      pop;
   tcur_pkg::queue_entry_type queue_head;
   logic                      queue_empty;

   // Classifies each accepted byte into carriage return, line feed, erase, tab or put.
   tcur_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_if     (req_if),
      .push       (push),
      .push_entry (push_entry),
      .queue_full (queue_full)
   );

   // Decouples the classifier from the executor so that each side stalls on its own.
   tcur_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (pop),
      .head       (queue_head),
      .empty      (queue_empty)
   );

   // Moves the cursor, wraps, scrolls and produces the result items.
   tcur_back u_back (
      .clock       (clock),
      .reset       (reset),
      .queue_empty (queue_empty),
      .queue_head  (queue_head),
      .pop         (pop),
      .csr_if      (csr_if),
      .rsp_if      (rsp_if)
   );

endmodule

// ===== bench/text_terminal_cursor_engine_test.sv =====
// Self-checking bench for the text terminal cursor engine: a scripted opening, then random
// phases under several screen sizes, every result item checked against a cursor model.
// Depends on tcur_pkg, the channel interfaces in tcur_ifs.sv and text_terminal_cursor_engine.
module text_terminal_cursor_engine_test;
   timeunit 1ns;
   timeprecision 1ps;

   // The longest honest silence is the deliberate hold-off on the result side plus a
   // drain, so a silence well beyond that with no item moving anywhere means a hang.
   localparam int QUIET_LIMIT  = 3000;
   localparam int HOLD_CYCLES  = 300;
   // A tab with a scroll is the longest operation in the back end; two queued operations
   // and the front end ahead of it still fit well inside this drain before registers change.
   localparam int DRAIN_CYCLES = 16;
   localparam int TAIL_CYCLES  = 20;
   localparam int GAP_PERCENT  = 19;
   localparam int PHASE_ITEMS  = 25;
   localparam int NUM_PHASES   = 5;
   localparam int HOLD_AFTER   = 50;

   // Register indexes with no register behind them; writes to them must change nothing.
   localparam logic [tcur_pkg::INDEX_W-1:0] CSR_SPARE_2 = 2'd2;
   localparam logic [tcur_pkg::INDEX_W-1:0] CSR_SPARE_3 = 2'd3;

   // One line of the opening script: either a register write or a character item. A few
   // character items carry their single result typed in by hand.
   typedef struct {
      bit                            is_reg;
      logic [tcur_pkg::INDEX_W-1:0]  idx;
      logic [tcur_pkg::DATA_W-1:0]   value;
      logic [tcur_pkg::CHAR_W-1:0]   code;
      bit                            typed;
      tcur_pkg::rsp_type             want;
   } script_line_type;

   logic clock;
   logic reset;

   tcur_req_if req_ch();
   tcur_rsp_if rsp_ch();
   tcur_csr_if csr_ch();

   text_terminal_cursor_engine dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch),
      .csr_if (csr_ch)
   );

   // Cursor model. The character cells are never read back by the block, so only the
   // cursor, the top row and the two size registers need to be tracked.
   int cur_col;
   int cur_row;
   int top_line;
   int reg_cols;
   int reg_rows;

   tcur_pkg::rsp_type step_out[$];   // result items caused by the character just modelled
   tcur_pkg::rsp_type awaited[$];    // result items still owed by the block, oldest first

   int mismatches;
   int results_seen;
   int quiet_cycles;
   bit no_gaps;
   bit sending_random;
   bit squeezed;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------------------------
   // Cursor model
   // ---------------------------------------------------------------------------------

   // A size register of zero behaves as one; anything above the maximum as the maximum.
   function automatic int clamp_size(input int value, input int limit);
      return (value == 0) ? 1 : ((value > limit) ? limit : value);
   endfunction

   function automatic void note_event(input tcur_pkg::event_kind_type kind, input int col,
                                      input int row,
                                      input logic [tcur_pkg::CHAR_W-1:0] ch);
      tcur_pkg::rsp_type r;
      r.event_kind  = kind;
      r.cell_column = tcur_pkg::COL_W'(col);
      r.cell_row    = tcur_pkg::ROW_W'(row);
      r.cell_char   = ch;
      r.top_row     = tcur_pkg::ROW_W'(top_line);
      r.last        = 1'b0;
      step_out.push_back(r);
   endfunction

   // Wrap at the right edge, then scroll if the cursor has dropped off the bottom row.
   // The scroll reports the top row after it has moved.
   function automatic void carry_line(input int nc, input int nr);
      if (cur_col >= nc) begin
         cur_col = 0;
         cur_row++;
      end
      if (cur_row >= nr) begin
         top_line++;
         if (top_line >= nr) top_line = 0;
         cur_row = nr - 1;
         note_event(tcur_pkg::EV_SCROLL, 0, 0, tcur_pkg::CH_SPACE);
      end
   endfunction

   function automatic void write_glyph(input logic [tcur_pkg::CHAR_W-1:0] ch, input int nc,
                                       input int nr);
      note_event(tcur_pkg::EV_CELL, cur_col, cur_row, ch);
      cur_col++;
      carry_line(nc, nr);
   endfunction

   function automatic void model_char(input logic [tcur_pkg::CHAR_W-1:0] code);
      int nc;
      int nr;
      int span;
      tcur_pkg::rsp_type tail;
      step_out.delete();
      nc = clamp_size(reg_cols, tcur_pkg::MAX_COLUMNS);
      nr = clamp_size(reg_rows, tcur_pkg::MAX_ROWS);
      if (cur_col >= nc) cur_col = nc - 1;
      if (cur_row >= nr) cur_row = nr - 1;
      if (top_line >= nr) top_line = 0;
      case (code)
         tcur_pkg::CH_CR: cur_col = 0;
         tcur_pkg::CH_LF: begin
            cur_col = 0;
            cur_row++;
            carry_line(nc, nr);
         end
         tcur_pkg::CH_BS, tcur_pkg::CH_DEL: begin
            if (cur_col != 0) begin
               cur_col--;
               note_event(tcur_pkg::EV_CELL, cur_col, cur_row, tcur_pkg::CH_SPACE);
            end
         end
         tcur_pkg::CH_TAB: begin
            // Spaces up to the next tab stop, but never past the right edge.
            span = tcur_pkg::TAB_STOP - (cur_col % tcur_pkg::TAB_STOP);
            if (span > nc - cur_col) span = nc - cur_col;
            repeat (span) write_glyph(tcur_pkg::CH_SPACE, nc, nr);
         end
         default: write_glyph(code, nc, nr);
      endcase
      if (step_out.size() > 0) begin
         tail = step_out[step_out.size() - 1];
         tail.last = 1'b1;
         step_out[step_out.size() - 1] = tail;
      end
   endfunction

   // Any write to a real register homes the cursor and the top row; the cells stay.
   function automatic void apply_reg(input logic [tcur_pkg::INDEX_W-1:0] idx,
                                     input logic [tcur_pkg::DATA_W-1:0] value);
      case (idx)
         tcur_pkg::CSR_COLUMNS: reg_cols = int'(value);
         tcur_pkg::CSR_ROWS:    reg_rows = int'(value[tcur_pkg::ROW_W-1:0]);
         default:               return;
      endcase
      cur_col  = 0;
      cur_row  = 0;
      top_line = 0;
   endfunction

   // ---------------------------------------------------------------------------------
   // Script lines and random characters
   // ---------------------------------------------------------------------------------

   function automatic script_line_type key(input logic [tcur_pkg::CHAR_W-1:0] code);
      script_line_type s;
      s.is_reg = 1'b0;
      s.idx    = tcur_pkg::CSR_COLUMNS;
      s.value  = '0;
      s.code   = code;
      s.typed  = 1'b0;
      s.want   = '0;
      return s;
   endfunction

   function automatic script_line_type key_is(input logic [tcur_pkg::CHAR_W-1:0] code,
                                              input tcur_pkg::event_kind_type kind,
                                              input int col, input int row,
                                              input logic [tcur_pkg::CHAR_W-1:0] ch,
                                              input int top);
      script_line_type s;
      s = key(code);
      s.typed            = 1'b1;
      s.want.event_kind  = kind;
      s.want.cell_column = tcur_pkg::COL_W'(col);
      s.want.cell_row    = tcur_pkg::ROW_W'(row);
      s.want.cell_char   = ch;
      s.want.top_row     = tcur_pkg::ROW_W'(top);
      s.want.last        = 1'b1;
      return s;
   endfunction

   function automatic script_line_type reg_wr(input logic [tcur_pkg::INDEX_W-1:0] idx,
                                              input logic [tcur_pkg::DATA_W-1:0] value);
      script_line_type s;
      s = key(8'h00);
      s.is_reg = 1'b1;
      s.idx    = idx;
      s.value  = value;
      return s;
   endfunction

   // Control codes are given a heavy share so that wraps, erases and scrolls are common.
   function automatic logic [tcur_pkg::CHAR_W-1:0] pick_char();
      int roll;
      roll = $urandom_range(99);
      if (roll < 8)  return tcur_pkg::CH_CR;
      if (roll < 20) return tcur_pkg::CH_LF;
      if (roll < 28) return tcur_pkg::CH_BS;
      if (roll < 34) return tcur_pkg::CH_DEL;
      if (roll < 46) return tcur_pkg::CH_TAB;
      return tcur_pkg::CHAR_W'($urandom_range(255));
   endfunction

   // ---------------------------------------------------------------------------------
   // Drivers
   // ---------------------------------------------------------------------------------

   // Offers one character item, with a random gap in front of it, and records the result
   // items it is due to cause once the block has taken it. Valid is only lowered when a
   // gap follows, so it never drops and rises within the same time step.
   task automatic send_char(input logic [tcur_pkg::CHAR_W-1:0] code, input bit typed,
                            input tcur_pkg::rsp_type want);
      int gap;
      gap = 0;
      if (!no_gaps) while ($urandom_range(99) < GAP_PERCENT) gap++;
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.char_code <= code;
      do @(posedge clock); while (!req_ch.ready);
      model_char(code);
      if (typed) begin
         if (step_out.size() != 1) begin
            $error("char %02h: model gives %0d result items where one is typed in",
                   code, step_out.size());
            mismatches++;
         end
         awaited.push_back(want);
      end else begin
         foreach (step_out[k]) awaited.push_back(step_out[k]);
      end
   endtask

   // Writes one register; the caller lowers valid once its batch of writes is over.
   task automatic set_reg(input logic [tcur_pkg::INDEX_W-1:0] idx,
                          input logic [tcur_pkg::DATA_W-1:0] value);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= value;
      do @(posedge clock); while (!csr_ch.ready);
      apply_reg(idx, value);
   endtask

   // Registers may only change while the block is idle. A carriage return leaves no
   // result behind, so an empty list of owed items is not enough on its own: a short
   // drain lets any such operation still in flight finish.
   task automatic wait_quiet();
      req_ch.valid <= 1'b0;
      while (awaited.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // ---------------------------------------------------------------------------------
   // Result side: ready with random stalls, and one long hold-off while the sender keeps
   // offering, so that the queue and output register fill and the input stalls.
   // ---------------------------------------------------------------------------------
   initial begin
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (sending_random && !squeezed && results_seen >= HOLD_AFTER) begin
            squeezed = 1'b1;
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            rsp_ch.ready <= no_gaps || ($urandom_range(99) >= GAP_PERCENT);
         end
      end
   end

   // Every accepted result item is compared field by field with the oldest owed item.
   always @(posedge clock) begin
      tcur_pkg::rsp_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         results_seen++;
         if (awaited.size() == 0) begin
            $error("result item with none owed: kind %0d col %0d row %0d char %02h top %0d",
                   rsp_ch.event_kind, rsp_ch.cell_column, rsp_ch.cell_row,
                   rsp_ch.cell_char, rsp_ch.top_row);
            mismatches++;
         end else begin
            want = awaited.pop_front();
            if (rsp_ch.event_kind !== want.event_kind) begin
               $error("event_kind: expected %0d, got %0d", want.event_kind, rsp_ch.event_kind);
               mismatches++;
            end
            if (rsp_ch.cell_column !== want.cell_column) begin
               $error("cell_column: expected %0d, got %0d", want.cell_column,
                      rsp_ch.cell_column);
               mismatches++;
            end
            if (rsp_ch.cell_row !== want.cell_row) begin
               $error("cell_row: expected %0d, got %0d", want.cell_row, rsp_ch.cell_row);
               mismatches++;
            end
            if (rsp_ch.cell_char !== want.cell_char) begin
               $error("cell_char: expected %02h, got %02h", want.cell_char, rsp_ch.cell_char);
               mismatches++;
            end
            if (rsp_ch.top_row !== want.top_row) begin
               $error("top_row: expected %0d, got %0d", want.top_row, rsp_ch.top_row);
               mismatches++;
            end
            if (rsp_ch.last !== want.last) begin
               $error("last: expected %0d, got %0d", want.last, rsp_ch.last);
               mismatches++;
            end
         end
      end
   end

   // Watchdog: any item moving on any channel counts as progress.
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_ch.valid && csr_ch.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ---------------------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------------------
   initial begin
      script_line_type script[$];
      int cols_pick;
      int rows_pick;

      reset            <= 1'b1;
      req_ch.valid     <= 1'b0;
      req_ch.char_code <= '0;
      csr_ch.valid     <= 1'b0;
      csr_ch.index     <= tcur_pkg::CSR_COLUMNS;
      csr_ch.data      <= '0;
      mismatches     = 0;
      results_seen   = 0;
      quiet_cycles   = 0;
      no_gaps        = 1'b0;
      sending_random = 1'b0;
      squeezed       = 1'b0;

      // State after reset: 80 by 40, cursor and top row at zero.
      cur_col  = 0;
      cur_row  = 0;
      top_line = 0;
      reg_cols = tcur_pkg::MAX_COLUMNS;
      reg_rows = tcur_pkg::MAX_ROWS;

      script = '{
         // Full-size screen straight after reset: printable byte, erase of it, erase at
         // the left edge (no result), both extremes of the byte, DEL, and the tab, carriage
         // return and line feed handling away from any edge.
         key_is(8'h41, tcur_pkg::EV_CELL, 0, 0, 8'h41, 0),
         key_is(tcur_pkg::CH_BS, tcur_pkg::EV_CELL, 0, 0, tcur_pkg::CH_SPACE, 0),
         key(tcur_pkg::CH_BS),
         key_is(8'h00, tcur_pkg::EV_CELL, 0, 0, 8'h00, 0),
         key_is(8'hFF, tcur_pkg::EV_CELL, 1, 0, 8'hFF, 0),
         key_is(tcur_pkg::CH_DEL, tcur_pkg::EV_CELL, 1, 0, tcur_pkg::CH_SPACE, 0),
         key(tcur_pkg::CH_TAB),
         key(tcur_pkg::CH_CR),
         key(tcur_pkg::CH_LF),
         key(tcur_pkg::CH_TAB),
         // Zero in both registers acts as a one by one screen: every item scrolls.
         reg_wr(tcur_pkg::CSR_COLUMNS, 7'h00),
         reg_wr(tcur_pkg::CSR_ROWS, 7'h00),
         key(8'h5A),
         key_is(tcur_pkg::CH_LF, tcur_pkg::EV_SCROLL, 0, 0, tcur_pkg::CH_SPACE, 0),
         // All-ones in both registers clamps to the full screen.
         reg_wr(tcur_pkg::CSR_COLUMNS, 7'h7F),
         reg_wr(tcur_pkg::CSR_ROWS, 7'h3F),
         key_is(8'h7E, tcur_pkg::EV_CELL, 0, 0, 8'h7E, 0),
         // Six by two: writes to the spare indexes must leave the cursor where it is,
         // a tab near the right edge stops at the edge, and wrapping off the bottom row
         // scrolls with the top row moving round.
         reg_wr(tcur_pkg::CSR_COLUMNS, 7'd6),
         reg_wr(tcur_pkg::CSR_ROWS, 7'd2),
         key(8'h61),
         key(8'h62),
         reg_wr(CSR_SPARE_2, 7'h55),
         reg_wr(CSR_SPARE_3, 7'h2A),
         key_is(8'h63, tcur_pkg::EV_CELL, 2, 0, 8'h63, 0),
         key(8'h64),
         key(tcur_pkg::CH_TAB),
         key(tcur_pkg::CH_TAB),
         key(tcur_pkg::CH_TAB),
         key_is(8'h71, tcur_pkg::EV_CELL, 0, 1, 8'h71, 1),
         key_is(tcur_pkg::CH_LF, tcur_pkg::EV_SCROLL, 0, 0, tcur_pkg::CH_SPACE, 0),
         // Four by one: a tab from the left edge gives four spaces and then a scroll,
         // the most result items one character can cause.
         reg_wr(tcur_pkg::CSR_COLUMNS, 7'd4),
         reg_wr(tcur_pkg::CSR_ROWS, 7'd1),
         key(tcur_pkg::CH_TAB)
      };

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Register writes come in batches; the block is drained before each batch and the
      // configuration valid is dropped after its last write.
      for (int i = 0; i < script.size(); i++) begin
         if (script[i].is_reg) begin
            if (i == 0 || !script[i - 1].is_reg) wait_quiet();
            set_reg(script[i].idx, script[i].value);
            if (i + 1 == script.size() || !script[i + 1].is_reg) csr_ch.valid <= 1'b0;
         end else begin
            send_char(script[i].code, script[i].typed, script[i].want);
         end
      end

      // Random phases. Small screens dominate so that wraps and scrolls come often; one
      // phase takes any columns value and any six-bit rows value, out-of-range ones included,
      // and the second phase runs with no gaps on either side.
      sending_random = 1'b1;
      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         wait_quiet();
         no_gaps = 1'b0;
         if (ph == 3) begin
            cols_pick = $urandom_range(127);
            rows_pick = $urandom_range(63);
         end else if (ph == 4) begin
            cols_pick = $urandom_range(tcur_pkg::MAX_COLUMNS, 8);
            rows_pick = $urandom_range(tcur_pkg::MAX_ROWS, 2);
         end else begin
            cols_pick = $urandom_range(12, 1);
            rows_pick = $urandom_range(4, 1);
         end
         set_reg(tcur_pkg::CSR_COLUMNS, tcur_pkg::DATA_W'(cols_pick));
         set_reg(tcur_pkg::CSR_ROWS, tcur_pkg::DATA_W'(rows_pick));
         csr_ch.valid <= 1'b0;
         no_gaps = (ph == 1);
         repeat (PHASE_ITEMS) send_char(pick_char(), 1'b0, '0);
      end
      sending_random = 1'b0;
      no_gaps        = 1'b0;

      // Let everything owed arrive, then give the block time to show any stray item.
      req_ch.valid <= 1'b0;
      while (awaited.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0) $display("DONE: 0 errors");
      else $display("DONE: errors detected");
      $finish;
   end

endmodule

// ===== filelist.f =====
src/tcur_pkg.sv
src/tcur_ifs.sv
src/tcur_front.sv
src/tcur_queue.sv
src/tcur_back.sv
src/text_terminal_cursor_engine.sv
bench/text_terminal_cursor_engine_test.sv
